// File: rtl/mmcg_pkg.sv
// ----------------------------------------------------------------------------
// mmcg_pkg
// Shared types, method codes and per-byte check functions for the
// multi-method check code generator.
// ----------------------------------------------------------------------------
package mmcg_pkg;

    localparam logic [2:0] METH_PARITY   = 3'd0;
    localparam logic [2:0] METH_PARITY2D = 3'd1;
    localparam logic [2:0] METH_CRC16    = 3'd2;
    localparam logic [2:0] METH_INET     = 3'd3;
    localparam logic [2:0] METH_HAMMING  = 3'd4;

    localparam logic [2:0]  METH_RESET = METH_CRC16;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [6:0]  CELLS      = 7'd64;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_byte;

    typedef struct packed {
        logic [15:0] check_value;
        logic        end_of_message;
    } t_result;

    function automatic logic byte_parity(input logic [7:0] d);
        byte_parity = ^d;
    endfunction

    // msb-first crc over one byte, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        crc_byte = c;
    endfunction

    // ones-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        oc_add = s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic logic [11:0] hamming_word(input logic [7:0] d);
        logic b1, b2, b4, b8;
        b1 = d[7] ^ d[6] ^ d[4] ^ d[3] ^ d[1];
        b2 = d[7] ^ d[5] ^ d[4] ^ d[2] ^ d[1];
        b4 = d[6] ^ d[5] ^ d[4] ^ d[0];
        b8 = d[3] ^ d[2] ^ d[1] ^ d[0];
        hamming_word = {b1, b2, d[7], b4, d[6], d[5], d[4], b8, d[3], d[2], d[1], d[0]};
    endfunction

    // toggles from space padding of cells n..63; a space has odd parity,
    // full rows pad evenly so only the partial row and column counts matter
    function automatic logic [15:0] pad_mask(input logic [6:0] n);
        logic [7:0] rows;
        logic [7:0] cols;
        logic [2:0] q;
        logic [2:0] m;
        logic       full_odd;
        rows     = 8'd0;
        cols     = 8'd0;
        q        = n[5:3];
        m        = n[2:0];
        full_odd = ~q[0];
        if (n < CELLS) begin
            rows[3'd7 - q] = m[0];
            for (int c = 0; c < 8; c++) begin
                cols[7 - c] = full_odd ^ (3'(c) >= m);
            end
        end
        pad_mask = {rows, cols};
    endfunction

endpackage

// File: rtl/mmcg_if.sv
// ----------------------------------------------------------------------------
// mmcg channel interfaces
// Valid/ready channels for message bytes in and check words out.
// ----------------------------------------------------------------------------
interface mmcg_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mmcg_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] check_value;
    logic        end_of_message;

    modport source (output valid, output check_value, output end_of_message, input ready);
    modport sink   (input valid, input check_value, input end_of_message, output ready);
endinterface

// File: rtl/mmcg_core.sv
// ----------------------------------------------------------------------------
// mmcg_core
// Method register and message accumulators; computes the result for one
// registered byte and updates all accumulators in parallel.
// ----------------------------------------------------------------------------
module mmcg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_fire,
    input  mmcg_pkg::t_byte   i_byte,
    output logic              o_res_valid,
    output mmcg_pkg::t_result o_res
);

    logic [2:0]  r_method;
    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_sum,  n_sum;
    logic [7:0]  r_held, n_held;
    logic        r_pend, n_pend;
    logic        r_par,  n_par;
    logic [7:0]  r_row,  n_row;
    logic [7:0]  r_col,  n_col;
    logic [6:0]  r_seen, n_seen;

    logic        p;
    logic [15:0] pad;
    logic [15:0] sum_fin;
    logic [15:0] value;
    logic        res_valid;

    always_comb begin
        p      = mmcg_pkg::byte_parity(i_byte.data_byte);
        n_par  = r_par ^ p;
        n_row  = r_row;
        n_col  = r_col;
        n_seen = r_seen;
        if (r_seen < mmcg_pkg::CELLS) begin
            n_row[3'd7 - r_seen[5:3]] = r_row[3'd7 - r_seen[5:3]] ^ p;
            n_col[3'd7 - r_seen[2:0]] = r_col[3'd7 - r_seen[2:0]] ^ p;
            n_seen = r_seen + 7'd1;
        end
        n_crc = mmcg_pkg::crc_byte(r_crc, i_byte.data_byte);
        if (r_pend) begin
            n_sum  = mmcg_pkg::oc_add(r_sum, {r_held, i_byte.data_byte});
            n_held = 8'd0;
            n_pend = 1'b0;
        end else begin
            n_sum  = r_sum;
            n_held = i_byte.data_byte;
            n_pend = 1'b1;
        end
        pad     = mmcg_pkg::pad_mask(n_seen);
        // odd length: pending high byte goes in as the top half of a word
        sum_fin = n_pend ? mmcg_pkg::oc_add(n_sum, {n_held, 8'h00}) : n_sum;

        case (r_method)
            mmcg_pkg::METH_PARITY:   value = {15'd0, n_par};
            mmcg_pkg::METH_PARITY2D: value = {n_row, n_col} ^ pad;
            mmcg_pkg::METH_CRC16:    value = n_crc;
            mmcg_pkg::METH_INET:     value = ~sum_fin;
            mmcg_pkg::METH_HAMMING:  value = {4'd0, mmcg_pkg::hamming_word(i_byte.data_byte)};
            default:                 value = 16'd0;
        endcase

        res_valid = (r_method == mmcg_pkg::METH_HAMMING) ||
                    (i_byte.last_byte && (r_method inside {[mmcg_pkg::METH_PARITY :
                                                             mmcg_pkg::METH_INET]}));
    end

    assign o_res_valid          = res_valid;
    assign o_res.check_value    = value;
    assign o_res.end_of_message = i_byte.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method <= mmcg_pkg::METH_RESET;
        end else if (i_cfg_we) begin
            r_method <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_byte.last_byte)) begin
            r_crc  <= mmcg_pkg::CRC_INIT;
            r_sum  <= 16'd0;
            r_held <= 8'd0;
            r_pend <= 1'b0;
            r_par  <= 1'b0;
            r_row  <= 8'd0;
            r_col  <= 8'd0;
            r_seen <= 7'd0;
        end else if (i_fire) begin
            r_crc  <= n_crc;
            r_sum  <= n_sum;
            r_held <= n_held;
            r_pend <= n_pend;
            r_par  <= n_par;
            r_row  <= n_row;
            r_col  <= n_col;
            r_seen <= n_seen;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_byte.last_byte) |=> (r_crc == mmcg_pkg::CRC_INIT && r_seen == 7'd0
                                          && !r_pend))
        else $error("accumulators not cleared after final byte");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= mmcg_pkg::CELLS)
        else $error("byte count beyond matrix size");

    a_held_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend |-> (r_held == 8'd0))
        else $error("held byte set with no half word pending");

endmodule

// File: rtl/multi_method_check_code_generator.sv
// ----------------------------------------------------------------------------
// multi_method_check_code_generator
// Byte-stream check code generator: parity, 8x8 2D parity, CRC-16,
// Internet checksum or per-byte Hamming(12,8).
// ----------------------------------------------------------------------------
// usage
//   i_byte carries one message byte per word with a last-byte mark. o_result
//   carries check words: for parity, 2D parity, crc and checksum one word on
//   the final byte only; for hamming one word per byte. i_cfg_we/i_cfg_data
//   set the method; the user must see that they are written only while the
//   block is idle, as the block itself does not enforce it. a byte from i_byte
//   passes the input register and then the result register. throughput:
//   one byte per cycle unless o_result stalls, set by the accumulator
//   update between the two registers; bytes with no word pass both stages.
//   reset: method returns to crc16, all accumulators return to their start
//   values and both stages empty; accumulators also restart after each
//   final byte. a stall on o_result holds the result register and the input
//   register; i_byte.ready drops once both are full.
// ----------------------------------------------------------------------------
module multi_method_check_code_generator (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_data,
    mmcg_byte_if.sink            i_byte,
    mmcg_result_if.source        o_result
);

    logic              r_s1_valid;
    mmcg_pkg::t_byte   r_s1;
    logic              r_out_valid;
    mmcg_pkg::t_result r_out;

    logic              s1_fire;
    logic              in_fire;
    logic              core_valid;
    mmcg_pkg::t_result core_res;

    assign s1_fire = r_s1_valid && (!r_out_valid || o_result.ready);
    assign in_fire = i_byte.valid && i_byte.ready;

    assign i_byte.ready            = !r_s1_valid || s1_fire;
    assign o_result.valid          = r_out_valid;
    assign o_result.check_value    = r_out.check_value;
    assign o_result.end_of_message = r_out.end_of_message;

    mmcg_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (s1_fire),
        .i_byte     (r_s1),
        .o_res_valid(core_valid),
        .o_res      (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1.data_byte <= i_byte.data_byte;
            r_s1.last_byte <= i_byte.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= core_valid;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && core_valid) begin
            r_out <= core_res;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |-> !s1_fire)
        else $error("result word overwritten while stalled");

    a_stage_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

    a_valid_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_result.ready) |=> r_out_valid)
        else $error("result word dropped while stalled");

endmodule
